FILE: src/heater_pid_step_assert.svh
// ---------------------------------------------------------------------------
// heater_pid_step assertion macros
// Shared property shorthands, clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef HEATER_PID_STEP_ASSERT_SVH
`define HEATER_PID_STEP_ASSERT_SVH

// same-cycle implication
`define HPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hps_pkg.sv
// ---------------------------------------------------------------------------
// hps_pkg
// Types and constants shared by the heater PID step pipeline.
// ---------------------------------------------------------------------------
package hps_pkg;

  localparam int TEMP_W     = 16;
  localparam int GAIN_W     = 8;
  localparam int ERR_W      = TEMP_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = 32;
  localparam int TICKS_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SETPOINT = 3'd0;
  localparam cfg_idx_t REG_GAIN_P   = 3'd1;
  localparam cfg_idx_t REG_GAIN_I   = 3'd2;
  localparam cfg_idx_t REG_GAIN_D   = 3'd3;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 8'd15;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 8'd2;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 8'd1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
  } hps_cfg_t;

  // per-item terms handed from the error stage to the multiplier stage
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  isum;  // zero when the integral is not used
    logic signed [DIFF_W-1:0] diff;  // zero when the derivative is not used
  } hps_terms_t;

endpackage

FILE: src/hps_regs.sv
// ---------------------------------------------------------------------------
// hps_regs
// Configuration register file: setpoint and the three loop gains.
// ---------------------------------------------------------------------------
module hps_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  hps_pkg::cfg_idx_t                wr_index,
  input  logic [hps_pkg::CFG_DATA_W-1:0]   wr_data,
  output hps_pkg::hps_cfg_t                cfg
);
  import hps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= '0;
      cfg.gain_p   <= GAIN_P_RST;
      cfg.gain_i   <= GAIN_I_RST;
      cfg.gain_d   <= GAIN_D_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SETPOINT: cfg.setpoint <= $signed(wr_data[TEMP_W-1:0]);
        REG_GAIN_P:   cfg.gain_p   <= wr_data[GAIN_W-1:0];
        REG_GAIN_I:   cfg.gain_i   <= wr_data[GAIN_W-1:0];
        REG_GAIN_D:   cfg.gain_d   <= wr_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/hps_integ.sv
// ---------------------------------------------------------------------------
// hps_integ
// Error stage: forms the error, keeps the saturating integral and the
// previous error, and gates the integral and derivative terms.
// ---------------------------------------------------------------------------
`include "heater_pid_step_assert.svh"

module hps_integ #(
  parameter int INTEGRAL_CUTOFF = 500,
  parameter int DERIV_THRESHOLD = 30
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic signed [hps_pkg::TEMP_W-1:0]   temp,
  input  logic signed [hps_pkg::TEMP_W-1:0]   setpoint,
  output hps_pkg::hps_terms_t                 terms
);
  import hps_pkg::*;

  localparam logic signed [ERR_W:0] CUTOFF_S = (ERR_W+1)'(INTEGRAL_CUTOFF);
  localparam logic signed [ERR_W:0] DERIV_S  = (ERR_W+1)'(DERIV_THRESHOLD);

  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  previous_error;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W:0]    err_x;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [SUM_W-1:0]  error_sum_next;
  logic signed [DIFF_W-1:0] diff;
  logic                     below_cut;
  logic                     overshoot;
  logic                     use_int;
  logic                     use_der;

  assign err       = $signed({setpoint[TEMP_W-1], setpoint}) - $signed({temp[TEMP_W-1], temp});
  assign err_x     = $signed({err[ERR_W-1], err});
  assign below_cut = err_x < CUTOFF_S;
  assign overshoot = err[ERR_W-1];
  assign use_der   = err_x > DERIV_S;

  // 33-bit add, then clamp to the 32-bit signed range
  assign sum_ext = $signed({error_sum[SUM_W-1], error_sum}) + (SUM_W+1)'(err);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
                               : $signed({1'b0, {(SUM_W-1){1'b1}}});
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    if (overshoot) begin
      error_sum_next = '0;
    end else if (below_cut) begin
      error_sum_next = sum_sat;
    end else begin
      error_sum_next = error_sum;
    end
  end

  assign use_int = below_cut && !overshoot;
  assign diff    = $signed({err[ERR_W-1], err}) -
                   $signed({previous_error[ERR_W-1], previous_error});

  assign terms.err  = err;
  assign terms.isum = use_int ? error_sum_next : '0;
  assign terms.diff = use_der ? diff : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (step) begin
      error_sum      <= error_sum_next;
      previous_error <= err;
    end
  end

  `HPS_ASSERT_NXT(a_overshoot_clears, step && overshoot, error_sum == '0,
                  "integral not cleared on overshoot")
  `HPS_ASSERT_NXT(a_cutoff_holds, step && !below_cut, $stable(error_sum),
                  "integral changed above cutoff")
  `HPS_ASSERT_NXT(a_prev_err, step, previous_error == $past(err),
                  "previous error not captured")

endmodule

FILE: src/heater_pid_step.sv
// ---------------------------------------------------------------------------
// heater_pid_step
// PID heater controller with conditional integration, one temperature
// sample in, one clamped heating-tick count out.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | request   | in_valid / in_ready  | measured_temp (s16)
//  out      | response  | out_valid / out_ready| heat_ticks (u13)
//  cfg      | write     | cfg_valid / cfg_ready| cfg_index (3b), cfg_data
//
//  Four-stage pipeline: input register, error/integral stage, multiplier
//  stage, sum-and-clamp output register. One request can enter every cycle
//  while out is not stalled; the integral and previous error update as a
//  sample moves into the error stage, which lets samples run back to back.
//  Each stage has its own valid bit and moves when the next one is free, so
//  bubbles close up and input is taken while a result waits at out. rst is
//  synchronous: clears valid bits, the integral, the previous error and
//  loads the register defaults. cfg_ready is always high; the user must
//  write configuration only while the pipeline is empty; it is not enforced.
// ---------------------------------------------------------------------------
`include "heater_pid_step_assert.svh"

module heater_pid_step #(
  parameter int HEAT_LIMIT      = 6000,
  parameter int INTEGRAL_CUTOFF = 500,
  parameter int DERIV_THRESHOLD = 30
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample request
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hps_pkg::TEMP_W-1:0]   measured_temp,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hps_pkg::TICKS_W-1:0]         heat_ticks,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  hps_pkg::cfg_idx_t                   cfg_index,
  input  logic [hps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hps_pkg::*;

  localparam int PP_W  = GAIN_W + 1 + ERR_W;   // gain_p * err
  localparam int PI_W  = GAIN_W + 1 + SUM_W;   // gain_i * integral
  localparam int PD_W  = GAIN_W + 1 + DIFF_W;  // gain_d * delta error
  localparam int TOT_W = PI_W + 2;
  localparam logic signed [TOT_W-1:0] LIMIT_S = TOT_W'(HEAT_LIMIT);

  hps_cfg_t   cfg;
  hps_terms_t terms;

  // stage valid bits and ready chain
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // payload registers
  logic signed [TEMP_W-1:0] s1_temp;
  hps_terms_t               s2_terms;
  logic signed [PP_W-1:0]   s3_pp;
  logic signed [PI_W-1:0]   s3_pi;
  logic signed [PD_W-1:0]   s3_pd;

  logic signed [GAIN_W:0]   gp_s, gi_s, gd_s;
  logic signed [PP_W-1:0]   pp_next;
  logic signed [PI_W-1:0]   pi_next;
  logic signed [PD_W-1:0]   pd_next;
  logic signed [TOT_W-1:0]  total;
  logic [TICKS_W-1:0]       heat_ticks_next;

  assign cfg_ready = 1'b1;

  hps_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a stage takes a new request when empty or when its content moves on
  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // error stage; state advances exactly once per sample
  hps_integ #(
    .INTEGRAL_CUTOFF (INTEGRAL_CUTOFF),
    .DERIV_THRESHOLD (DERIV_THRESHOLD)
  ) u_integ (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_valid && s2_ready),
    .temp     (s1_temp),
    .setpoint (cfg.setpoint),
    .terms    (terms)
  );

  // multiplier stage: gains are unsigned, widen by one bit before signed mult
  assign gp_s    = $signed({1'b0, cfg.gain_p});
  assign gi_s    = $signed({1'b0, cfg.gain_i});
  assign gd_s    = $signed({1'b0, cfg.gain_d});
  assign pp_next = gp_s * s2_terms.err;
  assign pi_next = gi_s * s2_terms.isum;
  assign pd_next = gd_s * s2_terms.diff;

  // sum and clamp to 0..HEAT_LIMIT, then keep the low 13 bits
  assign total = TOT_W'(s3_pp) + TOT_W'(s3_pi) + TOT_W'(s3_pd);
  always_comb begin
    if (total <= 0) begin
      heat_ticks_next = '0;
    end else if (total > LIMIT_S) begin
      heat_ticks_next = LIMIT_S[TICKS_W-1:0];
    end else begin
      heat_ticks_next = total[TICKS_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) s3_valid  <= s2_valid;
      if (s4_ready) out_valid <= s3_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_temp <= measured_temp;
    end
    if (s2_ready && s1_valid) begin
      s2_terms <= terms;
    end
    if (s3_ready && s2_valid) begin
      s3_pp <= pp_next;
      s3_pi <= pi_next;
      s3_pd <= pd_next;
    end
    if (s4_ready && s3_valid) begin
      heat_ticks <= heat_ticks_next;
    end
  end

  `HPS_ASSERT_IMP(a_ticks_limit, out_valid,
                  (HEAT_LIMIT > 8191) || (int'(heat_ticks) <= HEAT_LIMIT),
                  "heat_ticks above limit")
  `HPS_ASSERT_NXT(a_s3_hold, s3_valid && !s4_ready,
                  s3_valid && $stable(s3_pp) && $stable(s3_pi) && $stable(s3_pd),
                  "product stage lost or changed while stalled")
  `HPS_ASSERT_NXT(a_s2_hold, s2_valid && !s3_ready,
                  s2_valid && $stable(s2_terms),
                  "error stage lost or changed while stalled")

endmodule
